// ===== hw/rtl/tgnf_pkg.sv =====
// Shared types and constants for the triangle grid nearest free tile block.
// Request/response payloads, register map, pipeline tags and saturation limits.
// No dependencies.
package tgnf_pkg;

	// Request codes
	localparam logic REQ_MARK   = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	// Saturation limits for Q32.32 squared distances
	localparam logic [62:0] SAT63  = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] SQ_MAX = 32'd3037000499;

	// Configuration port
	localparam int CFG_AW = 4;

	typedef enum logic [1:0] {
		REG_EDGE_DIV = 2'd0,
		REG_U_STEP1  = 2'd1,
		REG_U_STEP2  = 2'd2,
		REG_V_STEP2  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [6:0]         edge_divisions;
		logic signed [31:0] u_step_edge1;
		logic signed [31:0] u_step_edge2;
		logic signed [31:0] v_step_edge2;
	} cfg_t;

	// Request and response payloads
	typedef struct packed {
		logic               req_type;
		logic [11:0]        tile_index;
		logic               occupied;
		logic signed [31:0] point_u;
		logic signed [31:0] point_v;
		logic [61:0]        limit_dist2;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [11:0] found_index;
		logic [62:0] result_dist2;
	} rsp_t;

	// Distance pipeline tags
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_F0   = 2'd1,
		KIND_F1   = 2'd2,
		KIND_TILE = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  flip;
	} iss_t;

	typedef struct packed {
		logic        valid;
		logic        occ;
		logic [62:0] d2;
	} dist_t;

endpackage

// ===== hw/rtl/tgnf_cfg_regs.sv =====
// Configuration register file behind an APB-style port.
// Holds edge count and the three Q16.16 step registers. Depends on tgnf_pkg.
module tgnf_cfg_regs import tgnf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_divisions <= 7'd1;
			cfg_q.u_step_edge1   <= '0;
			cfg_q.u_step_edge2   <= '0;
			cfg_q.v_step_edge2   <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_EDGE_DIV: cfg_q.edge_divisions <= pwdata[6:0];
				REG_U_STEP1:  cfg_q.u_step_edge1   <= pwdata;
				REG_U_STEP2:  cfg_q.u_step_edge2   <= pwdata;
				REG_V_STEP2:  cfg_q.v_step_edge2   <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_EDGE_DIV: prdata = {25'd0, cfg_q.edge_divisions};
			REG_U_STEP1:  prdata = cfg_q.u_step_edge1;
			REG_U_STEP2:  prdata = cfg_q.u_step_edge2;
			REG_V_STEP2:  prdata = cfg_q.v_step_edge2;
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/tgnf_occ_ram.sv =====
// Tile occupancy memory: one bit per tile, one write and one registered read port.
// No dependencies.
module tgnf_occ_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/tgnf_dist_pipe.sv =====
// Squared distance pipeline: abs/saturate, 32x32 square, add strip term.
// Also captures the per-strip v terms (f0, f1). Depends on tgnf_pkg.
module tgnf_dist_pipe import tgnf_pkg::*; #(
	parameter int DW = 42,
	parameter int HW = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iss_t                 iss,
	input  logic signed [DW-1:0] diff,
	input  logic [HW-1:0]        tile_idx,
	input  logic                 occ,
	output dist_t                res,
	output logic [HW-1:0]        res_idx,
	output logic                 busy
);

	// stage 1: registered difference
	kind_t                kind_s1;
	logic                 flip_s1;
	logic signed [DW-1:0] diff_s1;
	logic [HW-1:0]        idx_s1;
	logic [DW-1:0]        mag_s1;
	logic                 sat_s1;

	// stage 2: magnitude
	kind_t         kind_s2;
	logic          flip_s2;
	logic [HW-1:0] idx_s2;
	logic          occ_s2;
	logic          sat_s2;
	logic [31:0]   mag_s2;
	logic [63:0]   prod_s2;

	// stage 3: square
	kind_t         kind_s3;
	logic          flip_s3;
	logic [HW-1:0] idx_s3;
	logic          occ_s3;
	logic [62:0]   sq_s3;
	logic [62:0]   f_sel_s3;
	logic [63:0]   sum_s3;
	logic [62:0]   dist_s3;

	// strip terms and stage 4 output
	logic [62:0]   f0_q;
	logic [62:0]   f1_q;
	logic          valid_s4;
	logic          occ_s4;
	logic [62:0]   dist_s4;
	logic [HW-1:0] idx_s4;

	// control: tags and valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1  <= KIND_NONE;
			kind_s2  <= KIND_NONE;
			kind_s3  <= KIND_NONE;
			valid_s4 <= 1'b0;
		end else begin
			kind_s1  <= iss.kind;
			kind_s2  <= kind_s1;
			kind_s3  <= kind_s2;
			valid_s4 <= (kind_s3 == KIND_TILE);
		end
	end

	// abs and saturation check
	always_comb begin
		mag_s1 = diff_s1[DW-1] ? DW'(-diff_s1) : DW'(diff_s1);
		sat_s1 = mag_s1 > DW'(SQ_MAX);
	end

	assign prod_s2 = mag_s2 * mag_s2;

	// add strip term with saturation
	always_comb begin
		f_sel_s3 = flip_s3 ? f1_q : f0_q;
		sum_s3   = {1'b0, sq_s3} + {1'b0, f_sel_s3};
		dist_s3  = sum_s3[63] ? SAT63 : sum_s3[62:0];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		flip_s1 <= iss.flip;
		diff_s1 <= diff;
		idx_s1  <= tile_idx;

		flip_s2 <= flip_s1;
		idx_s2  <= idx_s1;
		occ_s2  <= occ;
		sat_s2  <= sat_s1;
		mag_s2  <= mag_s1[31:0];

		flip_s3 <= flip_s2;
		idx_s3  <= idx_s2;
		occ_s3  <= occ_s2;
		sq_s3   <= sat_s2 ? SAT63 : prod_s2[62:0];

		case (kind_s3)
			KIND_F0: f0_q <= sq_s3;
			KIND_F1: f1_q <= sq_s3;
			default: ;
		endcase

		occ_s4  <= occ_s3;
		dist_s4 <= dist_s3;
		idx_s4  <= idx_s3;
	end

	assign res.valid = valid_s4;
	assign res.occ   = occ_s4;
	assign res.d2    = dist_s4;
	assign res_idx   = idx_s4;
	assign busy      = (kind_s1 != KIND_NONE) || (kind_s2 != KIND_NONE) ||
	                   (kind_s3 != KIND_NONE) || valid_s4;

endmodule

// ===== hw/rtl/triangle_grid_nearest_free_tile.sv =====
// Triangle grid nearest free tile: top level with scan sequencer and best tracking.
// Uses tgnf_pkg, tgnf_cfg_regs, tgnf_occ_ram and tgnf_dist_pipe.
//
// Usage: a request (req) is taken on a clock edge where start is high and busy
// is low. Every request gives exactly one response on rsp, marked by done for
// one cycle; the receiver cannot stall it, so it must sample rsp when done is high.
// A mark request writes one occupancy bit and answers on the next cycle; busy
// stays low, so marks can follow each other every cycle.
// A search request scans the grid strip by strip: for each strip the states F0
// and F1 issue the v terms, then the tiles follow one per cycle through the
// distance pipeline. The single-port occupancy read and the one 32x32 squarer
// set the one-tile-per-cycle pace. busy is high for the whole search.
// After reset the occupancy memory is cleared one tile per cycle, all
// MAX_EDGE*MAX_EDGE tiles (4096 by default); busy is high meanwhile.
// Configuration writes through the APB port are taken at any time but must
// only change registers while no search is running.
module triangle_grid_nearest_free_tile import tgnf_pkg::*; #(
	parameter int MAX_EDGE = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              done,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int DEPTH = MAX_EDGE * MAX_EDGE;
	localparam int HW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = $clog2(MAX_EDGE + 1);
	localparam int TW    = $clog2(2 * MAX_EDGE);
	localparam int CW    = $clog2(3 * MAX_EDGE + 2);
	localparam int AW    = 32 + CW;
	localparam int DW    = AW + 2;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_F0    = 6'b000100,
		ST_F1    = 6'b001000,
		ST_TILE  = 6'b010000,
		ST_DRAIN = 6'b100000
	} state_t;

	cfg_t   cfg;
	state_t state_q;
	state_t state_d;

	// sequencer
	logic [HW-1:0] clr_q;
	logic [EW-1:0] r_q;
	logic [TW-1:0] t_q;
	logic [HW-1:0] h_q;
	logic [EW-1:0] n_eff;
	logic          accept;
	logic          strip_end;
	logic          pipe_busy;

	// search operands and accumulators
	logic signed [31:0]   pu_q;
	logic signed [31:0]   pv_q;
	logic [61:0]          limit_q;
	logic signed [AW-1:0] a_q;
	logic signed [AW-1:0] b_q;
	logic signed [AW-1:0] c_q;
	logic signed [AW-1:0] u1x;
	logic signed [AW-1:0] u2x;
	logic signed [AW-1:0] v2x;
	logic signed [DW-1:0] cu0;
	logic signed [DW-1:0] cu1;
	logic signed [DW-1:0] dv0;
	logic signed [DW-1:0] diff;

	// best tracking
	logic          found_q;
	logic [HW-1:0] best_q;
	logic [62:0]   d2_q;
	logic          cand;

	// memory and pipe interface
	logic          mem_we;
	logic [HW-1:0] mem_waddr;
	logic          mem_wdata;
	logic          mem_rdata;
	iss_t          iss;
	dist_t         pres;
	logic [HW-1:0] pres_idx;

	logic done_q;
	rsp_t rsp_q;

	tgnf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tgnf_occ_ram #(.DEPTH(DEPTH), .AW(HW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (h_q),
		.rdata (mem_rdata)
	);

	tgnf_dist_pipe #(.DW(DW), .HW(HW)) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.iss      (iss),
		.diff     (diff),
		.tile_idx (h_q),
		.occ      (mem_rdata),
		.res      (pres),
		.res_idx  (pres_idx),
		.busy     (pipe_busy)
	);

	// effective edge count: zero acts as one, clamp at MAX_EDGE
	always_comb begin
		if (cfg.edge_divisions == 7'd0) begin
			n_eff = EW'(1);
		end else if (32'(cfg.edge_divisions) > 32'(MAX_EDGE)) begin
			n_eff = EW'(MAX_EDGE);
		end else begin
			n_eff = EW'(cfg.edge_divisions);
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && (state_q == ST_IDLE);
	assign strip_end = (t_q == TW'({r_q, 1'b0}));

	// tile center and differences
	always_comb begin
		u1x = AW'(cfg.u_step_edge1);
		u2x = AW'(cfg.u_step_edge2);
		v2x = AW'(cfg.v_step_edge2);
		cu0 = DW'(a_q) + DW'(b_q);
		cu1 = cu0 + DW'(u1x) + DW'(u2x);
		dv0 = DW'(pv_q) - DW'(c_q);
	end

	// issue to the distance pipe
	always_comb begin
		iss.flip = t_q[0];
		iss.kind = KIND_NONE;
		diff     = DW'(pu_q) - (t_q[0] ? cu1 : cu0);
		unique case (state_q)
			ST_F0: begin
				iss.kind = KIND_F0;
				diff     = dv0;
			end
			ST_F1: begin
				iss.kind = KIND_F1;
				diff     = dv0 - DW'(v2x);
			end
			ST_TILE: iss.kind = KIND_TILE;
			default: ;
		endcase
	end

	// memory writes: clearing pass and marks
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = HW'(req.tile_index);
		mem_wdata = req.occupied;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = 1'b0;
		end else if (accept && req.req_type == REQ_MARK &&
		             32'(req.tile_index) < 32'(DEPTH)) begin
			mem_we = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == HW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (accept && req.req_type == REQ_SEARCH) state_d = ST_F0;
			ST_F0:    state_d = ST_F1;
			ST_F1:    state_d = ST_TILE;
			ST_TILE: begin
				if (strip_end) begin
					state_d = (r_q == '0) ? ST_DRAIN : ST_F0;
				end
			end
			ST_DRAIN: if (!pipe_busy) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			r_q     <= '0;
			t_q     <= '0;
			h_q     <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + HW'(1);
				ST_IDLE: begin
					if (accept) begin
						done_q  <= (req.req_type == REQ_MARK);
						r_q     <= n_eff - EW'(1);
						found_q <= 1'b0;
					end
				end
				ST_F0: begin
					t_q <= '0;
					h_q <= HW'(r_q) * HW'(r_q);
				end
				ST_F1: ;
				ST_TILE: begin
					t_q <= t_q + TW'(1);
					h_q <= h_q + HW'(1);
					if (strip_end && r_q != '0) begin
						r_q <= r_q - EW'(1);
					end
				end
				ST_DRAIN: if (!pipe_busy) done_q <= 1'b1;
				default: ;
			endcase
			if (cand && !pres.occ) begin
				found_q <= 1'b1;
			end
		end
	end

	// candidate check on a finished tile
	assign cand = pres.valid && (pres.d2 < {1'b0, limit_q}) &&
	              (!found_q || pres.d2 < d2_q);

	// search payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pu_q    <= req.point_u;
			pv_q    <= req.point_v;
			limit_q <= req.limit_dist2;
			d2_q    <= {req.limit_dist2, 1'b1};
			best_q  <= '0;
			b_q     <= AW'(cfg.u_step_edge2);
			c_q     <= AW'(cfg.v_step_edge2);
		end else begin
			if (cand) begin
				if (!pres.occ) begin
					best_q <= pres_idx;
					d2_q   <= pres.d2;
				end else if (!found_q && pres.d2 < d2_q) begin
					d2_q <= pres.d2;
				end
			end
			if (state_q == ST_F0) begin
				a_q <= u1x;
			end else if (state_q == ST_TILE) begin
				if (t_q[0]) begin
					a_q <= a_q + (u1x <<< 1) + u1x;
				end
				if (strip_end) begin
					b_q <= b_q + (u2x <<< 1) + u2x;
					c_q <= c_q + (v2x <<< 1) + v2x;
				end
			end
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (accept && req.req_type == REQ_MARK) begin
			rsp_q <= '0;
		end else if (state_q == ST_DRAIN && !pipe_busy) begin
			rsp_q.found        <= found_q;
			rsp_q.found_index  <= 12'(best_q);
			rsp_q.result_dist2 <= d2_q;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== tb/sv/triangle_grid_nearest_free_tile_test.sv =====
// Testbench for triangle_grid_nearest_free_tile: directed and random mark/search requests
// checked against a scoreboard that predicts each search over its own occupancy copy.
// Depends on tgnf_pkg and the triangle_grid_nearest_free_tile RTL.
module triangle_grid_nearest_free_tile_test;
	import tgnf_pkg::*;

	localparam int GRID_MAX    = 64;
	localparam int CYCLE_LIMIT = 2000000;

	// Scoreboard: occupancy copy, register copy and queue of predicted responses
	class free_tile_scoreboard;
		bit                  occ_map [GRID_MAX*GRID_MAX];
		logic [6:0]          edge_div;
		longint              u_step1;
		longint              u_step2;
		longint              v_step2;
		rsp_t                pending_answers [$];
		int                  mismatches;

		function new();
			foreach (occ_map[t]) occ_map[t] = 1'b0;
			edge_div   = 7'd1;
			u_step1    = 0;
			u_step2    = 0;
			v_step2    = 0;
			mismatches = 0;
		endfunction

		task report_mismatch(input string what);
			$display("mismatch: %s", what);
			mismatches++;
		endtask

		function void set_register(input reg_idx_t idx, input logic [31:0] value);
			case (idx)
				REG_EDGE_DIV: edge_div = value[6:0];
				REG_U_STEP1:  u_step1  = longint'($signed(value));
				REG_U_STEP2:  u_step2  = longint'($signed(value));
				REG_V_STEP2:  v_step2  = longint'($signed(value));
				default: ;
			endcase
		endfunction

		// Square of a Q16.16 difference, saturated to 63 bits
		function longint unsigned square_sat(input longint d);
			longint unsigned a;
			a = (d < 0) ? longint'(-d) : longint'(d);
			if (a > 64'(SQ_MAX))
				return 64'(SAT63);
			return a * a;
		endfunction

		function longint unsigned add_sat(input longint unsigned a, input longint unsigned b);
			longint unsigned s;
			s = a + b;
			if (s > 64'(SAT63))
				s = 64'(SAT63);
			return s;
		endfunction

		// Scan strips, stripes and flips; keep the first strictly nearer free tile
		function rsp_t predict_nearest_free(input req_t r);
			rsp_t            res;
			int              n;
			int              span;
			int              last;
			int              row;
			int              h;
			longint          pu;
			longint          pv;
			longint          cu;
			longint unsigned lim;
			longint unsigned f0;
			longint unsigned f1;
			longint unsigned tile_d2;
			longint unsigned best_d2;
			bit              hit;
			logic [11:0]     best;
			n = int'(edge_div);
			if (n < 1) n = 1;
			if (n > GRID_MAX) n = GRID_MAX;
			pu      = longint'($signed(r.point_u));
			pv      = longint'($signed(r.point_v));
			lim     = 64'(r.limit_dist2);
			best_d2 = 2 * lim + 1;
			hit     = 1'b0;
			best    = '0;
			for (int k = 0; k < n; k++) begin
				f0   = square_sat(pv - longint'(3 * k + 1) * v_step2);
				f1   = square_sat(pv - longint'(3 * k + 2) * v_step2);
				span = n - k;
				if (f0 > lim && f1 > lim)
					continue;
				for (int j = 0; j < span; j++) begin
					last = (j != span - 1) ? 1 : 0;
					for (int i = 0; i <= last; i++) begin
						cu      = longint'(3 * j + i + 1) * u_step1 +
						          longint'(3 * k + i + 1) * u_step2;
						tile_d2 = add_sat(square_sat(pu - cu), (i != 0) ? f1 : f0);
						if (tile_d2 < lim && (!hit || tile_d2 < best_d2)) begin
							row = n - k - 1;
							h   = row * row + 2 * j + i;
							if (h < GRID_MAX * GRID_MAX && !occ_map[h]) begin
								hit     = 1'b1;
								best    = 12'(h);
								best_d2 = tile_d2;
							end else if (!hit && tile_d2 < best_d2) begin
								best_d2 = tile_d2;
							end
						end
					end
				end
			end
			res.found        = hit;
			res.found_index  = best;
			res.result_dist2 = best_d2[62:0];
			return res;
		endfunction

		function void note_request(input req_t r);
			rsp_t res;
			if (r.req_type == REQ_MARK) begin
				if (int'(r.tile_index) < GRID_MAX * GRID_MAX)
					occ_map[r.tile_index] = r.occupied;
				res = '0;
			end else begin
				res = predict_nearest_free(r);
			end
			pending_answers.push_back(res);
		endfunction

		task check_result(input rsp_t got);
			rsp_t want;
			if (pending_answers.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				want = pending_answers.pop_front();
				if (got.found !== want.found)
					report_mismatch($sformatf("found %0d, want %0d", got.found, want.found));
				if (got.found_index !== want.found_index)
					report_mismatch($sformatf("found_index %0d, want %0d",
						got.found_index, want.found_index));
				if (got.result_dist2 !== want.result_dist2)
					report_mismatch($sformatf("result_dist2 %h, want %h",
						got.result_dist2, want.result_dist2));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	req_t              req;
	logic              done;
	rsp_t              rsp;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	free_tile_scoreboard board;
	int                  grid_n;
	bit                  steady;
	int                  cycles;

	triangle_grid_nearest_free_tile dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Response check first, then the request taken on the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_result(rsp);
			if (start && !busy)
				board.note_request(req);
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	task send_request(input req_t r);
		while (!steady && $urandom_range(0, 99) < 34) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		req   = r;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task write_register(input reg_idx_t idx, input logic [31:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		board.set_register(idx, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task drain;
		start = 1'b0;
		while (board.pending_answers.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task set_grid(input logic [6:0] n, input logic [31:0] u1, input logic [31:0] u2,
		input logic [31:0] v2);
		write_register(REG_EDGE_DIV, {25'd0, n});
		write_register(REG_U_STEP1, u1);
		write_register(REG_U_STEP2, u2);
		write_register(REG_V_STEP2, v2);
		grid_n = (n == 0) ? 1 : ((n > GRID_MAX) ? GRID_MAX : int'(n));
	endtask

	function req_t mark_tile(input logic [11:0] t, input logic o);
		req_t r;
		r            = '0;
		r.req_type   = REQ_MARK;
		r.tile_index = t;
		r.occupied   = o;
		return r;
	endfunction

	function req_t search_at(input logic [31:0] pu, input logic [31:0] pv, input logic [61:0] lim);
		req_t r;
		r             = '0;
		r.req_type    = REQ_SEARCH;
		r.point_u     = pu;
		r.point_v     = pv;
		r.limit_dist2 = lim;
		return r;
	endfunction

	// Mostly in-grid marks and searches near the triangle; some noise and extremes
	function req_t random_request();
		req_t        r;
		int          pick;
		int          sel;
		logic [63:0] wide;
		pick          = $urandom_range(0, 99);
		r.tile_index  = 12'($urandom);
		r.occupied    = 1'($urandom_range(0, 1));
		r.point_u     = $urandom;
		r.point_v     = $urandom;
		wide          = {$urandom, $urandom};
		r.limit_dist2 = wide[61:0];
		if (pick < 40) begin
			r.req_type = REQ_MARK;
			if (pick < 34)
				r.tile_index = 12'($urandom_range(0, grid_n * grid_n - 1));
		end else begin
			r.req_type = REQ_SEARCH;
			if (pick < 88) begin
				r.point_u = 32'($urandom_range(0, (3 * grid_n + 2) << 16)) - 32'h10000;
				r.point_v = 32'($urandom_range(0, (3 * grid_n + 2) << 16)) - 32'h10000;
			end
			sel = $urandom_range(0, 9);
			if (sel == 0)
				r.limit_dist2 = '0;
			else if (sel == 1)
				r.limit_dist2 = '1;
			else if (sel > 2) begin
				wide          = {32'($urandom_range(0, 9 * grid_n * grid_n + 9)), $urandom};
				r.limit_dist2 = wide[61:0];
			end
		end
		return r;
	endfunction

	initial begin
		logic [6:0] n;
		board   = new();
		cycles  = 0;
		grid_n  = 1;
		steady  = 1'b0;
		arst_n  = 1'b0;
		start   = 1'b0;
		req     = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed: single tile at the origin with reset registers
		send_request(search_at(32'h0, 32'h0, 62'd1));
		send_request(search_at(32'h0, 32'h0, 62'd0));
		send_request(mark_tile(12'd0, 1'b1));
		send_request(search_at(32'h0, 32'h0, '1));
		send_request(search_at(32'h7FFF_FFFF, 32'h8000_0000, '1));
		send_request(search_at(32'h8000_0000, 32'h7FFF_FFFF, '1));
		send_request(search_at(32'hFFFF_FFFF, 32'hFFFF_FFFF, '1));
		// marks above the grid are stored but never searched
		send_request(mark_tile(12'd4095, 1'b1));
		send_request(mark_tile(12'd4095, 1'b0));
		send_request(mark_tile(12'd0, 1'b0));
		send_request(search_at(32'h0001_0000, 32'h0, 62'h2_0000_0000));
		// limit equal to the distance is not a hit
		send_request(search_at(32'h0001_0000, 32'h0, 62'h1_0000_0000));
		send_request(mark_tile(12'd1, 1'b1));
		drain();

		// Directed: two tiles per edge, both flips
		set_grid(7'd2, 32'h0001_0000, 32'h0000_8000, 32'h0000_DDB3);
		send_request(search_at(32'h0001_8000, 32'h0001_0000, '1));
		send_request(search_at(32'h0004_0000, 32'h0004_0000, 62'h40_0000_0000));
		send_request(mark_tile(12'd1, 1'b0));
		send_request(mark_tile(12'd3, 1'b1));
		send_request(search_at(32'h0001_8000, 32'h0001_0000, '1));
		send_request(search_at(32'h0004_0000, 32'h0004_0000, 62'h40_0000_0000));
		drain();

		// Random phases over several grid settings
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: set_grid(7'd64, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
				1: set_grid(7'd0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
				2: set_grid(7'd127, 32'h0001_0000, 32'hFFFF_8000, 32'h0000_DDB3);
				8: set_grid(7'($urandom_range(1, 8)), $urandom, $urandom, $urandom);
				default: begin
					n = (p == 6) ? 7'($urandom_range(11, 40)) : 7'($urandom_range(1, 10));
					set_grid(n, 32'($urandom_range(32'h4000, 32'h2_0000)),
						32'($urandom_range(0, 32'h2_0000)) - 32'h1_0000,
						32'($urandom_range(32'h4000, 32'h2_0000)));
				end
			endcase
			steady = (p == 4 || p == 5);
			repeat (9) send_request(random_request());
			drain();
		end

		repeat (20) @(negedge clk);
		if (board.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
